FILE: hw/rtl/mhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared widths, operation and status codes, and controller states for the
// min-heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int KEY_W        = 32;
  localparam int ID_W         = 16;
  localparam int OP_W         = 2;
  localparam int STATUS_W     = 2;
  localparam int ENTRIES_W    = 11;
  localparam int CAPACITY_DEF = 1024;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_CHANGE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_POP_ROOT,
    S_POP_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_DEC,
    S_SRCH,
    S_CHG_PAR
  } state_t;

endpackage

FILE: hw/rtl/min_heap_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core
// binary min-heap of (key, id) pairs kept in one single-port-read memory
// ----------------------------------------------------------------------------
// usage:
//   a command (op, key, node_id) is taken at a clock edge where start is high
//   and busy is low. op selects insert, pop minimum or change of priority.
//   one result (status, popped_id, entries) comes back per command, shown for
//   exactly one cycle while done is high; the receiver cannot stall it.
//   a new command may be started in the same cycle that done is high.
// steps, shaped by the heap memory (one read and one write port, registered
// read) and walked one level at a time:
//   full insert, empty pop, unknown op: result in the cycle after the transfer
//   insert: each level climbed reads the parent, then compares and writes;
//   it ends with a write at the root or where it stops lower
//   pop: root, then last entry read; per level descended: left child, right
//   child, decide and write; ends at a leaf, where it stops, or on the last entry
//   change: one cycle per entry searched, then the parent of an entry below
//   the root is tested, then an up or down walk as above
// reset (rst, synchronous) empties the heap at once; memory contents are
// left as they are, since only entries below the fill count are ever read.
// the sift walks carry the moving entry in a register and only write the
// displaced entries, so each level costs one write instead of a swap.
// ----------------------------------------------------------------------------
module min_heap_priority_queue_core #(
  parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [mhpq_pkg::OP_W-1:0]           op,
  input  logic [mhpq_pkg::KEY_W-1:0]          key,
  input  logic [mhpq_pkg::ID_W-1:0]           node_id,
  output logic                                done,
  output logic [mhpq_pkg::STATUS_W-1:0]       status,
  output logic [mhpq_pkg::ID_W-1:0]           popped_id,
  output logic [mhpq_pkg::ENTRIES_W-1:0]      entries
);

  localparam int KW = mhpq_pkg::KEY_W;
  localparam int IW = mhpq_pkg::ID_W;
  localparam int EW = mhpq_pkg::ENTRIES_W;
  localparam int DW = KW + IW;                  // memory word: {key, id}
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);     // fill count, holds CAPACITY
  localparam int XW = AW + 2;                   // child index before range check

  mhpq_pkg::state_t state, state_next;

  // heap storage
  logic [DW-1:0] mem [CAPACITY];
  logic [DW-1:0] rd_data;
  logic          mem_re;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;

  // walk registers
  logic [CW-1:0] fill;
  logic [AW-1:0] pos;
  logic [AW-1:0] idx;
  logic [KW-1:0] mov_key;
  logic [IW-1:0] mov_id;
  logic [KW-1:0] c_key;       // left child held while the right one is read
  logic [IW-1:0] c_id;
  logic          c_pick;      // left child beats the moving entry
  logic          has_r;       // right child exists
  logic [IW-1:0] pop_id;

  // marks that the running walk belongs to a pop
  logic          pop_id_valid;

  // finish control
  logic                          fin;
  logic                          fin_pop;
  logic [mhpq_pkg::STATUS_W-1:0] fin_status;

  // derived index and compare terms
  logic [KW-1:0] rd_key;
  logic [IW-1:0] rd_id;
  logic [AW-1:0] par;
  logic [XW-1:0] lc_x;
  logic [XW-1:0] rc_x;
  logic [XW-1:0] fill_x;
  logic          lc_in;
  logic          rc_in;
  logic          up_swap;
  logic          pick_r;
  logic          srch_hit;
  logic          srch_last;
  logic          is_full;
  logic          is_empty;
  logic          take;

  assign rd_key   = rd_data[DW-1:IW];
  assign rd_id    = rd_data[IW-1:0];
  assign par      = AW'((pos - AW'(1)) >> 1);
  assign lc_x     = {1'b0, pos, 1'b1};
  assign rc_x     = {1'b0, pos, 1'b0} + XW'(2);
  assign fill_x   = XW'(fill);
  assign lc_in    = lc_x < fill_x;
  assign rc_in    = rc_x < fill_x;
  // parent strictly greater: the moving entry climbs
  assign up_swap  = rd_key > mov_key;
  // right child must beat the best of (moving entry, left child)
  assign pick_r   = has_r && (rd_key < (c_pick ? c_key : mov_key));
  assign srch_hit = rd_id == mov_id;
  assign srch_last = (CW'(idx) + CW'(1)) == fill;
  assign is_full  = fill == CW'(CAPACITY);
  assign is_empty = fill == '0;
  assign take     = start && (state == mhpq_pkg::S_IDLE);
  assign busy     = state != mhpq_pkg::S_IDLE;

  // memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mhpq_pkg::S_IDLE: begin
        if (take) begin
          case (op)
            mhpq_pkg::OP_INSERT: if (!is_full) state_next = mhpq_pkg::S_UP_CHK;
            mhpq_pkg::OP_POP:    if (!is_empty) state_next = mhpq_pkg::S_POP_ROOT;
            mhpq_pkg::OP_CHANGE: if (!is_empty) state_next = mhpq_pkg::S_SRCH;
            default:             state_next = mhpq_pkg::S_IDLE;
          endcase
        end
      end
      mhpq_pkg::S_UP_CHK: begin
        state_next = (pos == '0) ? mhpq_pkg::S_IDLE : mhpq_pkg::S_UP_CMP;
      end
      mhpq_pkg::S_UP_CMP: begin
        state_next = up_swap ? mhpq_pkg::S_UP_CHK : mhpq_pkg::S_IDLE;
      end
      mhpq_pkg::S_POP_ROOT: begin
        state_next = mhpq_pkg::S_POP_LAST;
      end
      mhpq_pkg::S_POP_LAST: begin
        state_next = is_empty ? mhpq_pkg::S_IDLE : mhpq_pkg::S_DN_L;
      end
      mhpq_pkg::S_DN_L: begin
        state_next = lc_in ? mhpq_pkg::S_DN_R : mhpq_pkg::S_IDLE;
      end
      mhpq_pkg::S_DN_R: begin
        state_next = mhpq_pkg::S_DN_DEC;
      end
      mhpq_pkg::S_DN_DEC: begin
        state_next = (pick_r || c_pick) ? mhpq_pkg::S_DN_L : mhpq_pkg::S_IDLE;
      end
      mhpq_pkg::S_SRCH: begin
        if (srch_hit) begin
          state_next = (idx == '0) ? mhpq_pkg::S_DN_L : mhpq_pkg::S_CHG_PAR;
        end else if (srch_last) begin
          state_next = mhpq_pkg::S_IDLE;
        end
      end
      mhpq_pkg::S_CHG_PAR: begin
        state_next = (mov_key < rd_key) ? mhpq_pkg::S_UP_CHK : mhpq_pkg::S_DN_L;
      end
      default: state_next = mhpq_pkg::S_IDLE;
    endcase
  end

  // memory control and finish
  always_comb begin
    mem_re     = 1'b0;
    rd_addr    = '0;
    mem_we     = 1'b0;
    wr_addr    = pos;
    wr_data    = {mov_key, mov_id};
    fin        = 1'b0;
    fin_pop    = 1'b0;
    fin_status = mhpq_pkg::STAT_OK;
    case (state)
      mhpq_pkg::S_IDLE: begin
        if (take) begin
          case (op)
            mhpq_pkg::OP_INSERT: begin
              if (is_full) begin
                fin        = 1'b1;
                fin_status = mhpq_pkg::STAT_FULL;
              end
            end
            mhpq_pkg::OP_POP: begin
              if (is_empty) begin
                fin        = 1'b1;
                fin_status = mhpq_pkg::STAT_EMPTY;
              end else begin
                mem_re = 1'b1;   // root
              end
            end
            mhpq_pkg::OP_CHANGE: begin
              if (is_empty) begin
                fin        = 1'b1;
                fin_status = mhpq_pkg::STAT_NOTFOUND;
              end else begin
                mem_re = 1'b1;   // first entry of the search
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      mhpq_pkg::S_UP_CHK: begin
        if (pos == '0) begin
          mem_we = 1'b1;
          fin    = 1'b1;
        end else begin
          mem_re  = 1'b1;
          rd_addr = par;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        mem_we = 1'b1;
        if (up_swap) begin
          wr_data = rd_data;     // parent moves down into the hole
        end else begin
          fin = 1'b1;
        end
      end
      mhpq_pkg::S_POP_ROOT: begin
        mem_re  = 1'b1;
        rd_addr = AW'(fill);     // last entry, count already lowered
      end
      mhpq_pkg::S_POP_LAST: begin
        if (is_empty) begin
          fin     = 1'b1;
          fin_pop = 1'b1;
        end
      end
      mhpq_pkg::S_DN_L: begin
        if (lc_in) begin
          mem_re  = 1'b1;
          rd_addr = lc_x[AW-1:0];
        end else begin
          mem_we  = 1'b1;
          fin     = 1'b1;
          fin_pop = pop_id_valid;
        end
      end
      mhpq_pkg::S_DN_R: begin
        if (rc_in) begin
          mem_re  = 1'b1;
          rd_addr = rc_x[AW-1:0];
        end
      end
      mhpq_pkg::S_DN_DEC: begin
        mem_we = 1'b1;
        if (pick_r) begin
          wr_data = rd_data;
        end else if (c_pick) begin
          wr_data = {c_key, c_id};
        end else begin
          fin     = 1'b1;
          fin_pop = pop_id_valid;
        end
      end
      mhpq_pkg::S_SRCH: begin
        if (srch_hit) begin
          if (idx != '0) begin
            mem_re  = 1'b1;
            rd_addr = AW'((idx - AW'(1)) >> 1);
          end
        end else if (srch_last) begin
          fin        = 1'b1;
          fin_status = mhpq_pkg::STAT_NOTFOUND;
        end else begin
          mem_re  = 1'b1;
          rd_addr = idx + AW'(1);
        end
      end
      mhpq_pkg::S_CHG_PAR: begin
        if (mov_key < rd_key) begin
          mem_we  = 1'b1;
          wr_data = rd_data;     // first climb step, parent already read
        end
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mhpq_pkg::S_IDLE;
      fill         <= '0;
      done         <= 1'b0;
      pop_id_valid <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (take) begin
        pop_id_valid <= (op == mhpq_pkg::OP_POP) && !is_empty;
        if ((op == mhpq_pkg::OP_INSERT) && !is_full) begin
          fill <= fill + CW'(1);
        end else if ((op == mhpq_pkg::OP_POP) && !is_empty) begin
          fill <= fill - CW'(1);
        end
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      mhpq_pkg::S_IDLE: begin
        if (take) begin
          mov_key <= key;
          mov_id  <= node_id;
          pos     <= AW'(fill);
          idx     <= '0;
        end
      end
      mhpq_pkg::S_UP_CMP: begin
        if (up_swap) begin
          pos <= par;
        end
      end
      mhpq_pkg::S_POP_ROOT: begin
        pop_id <= rd_id;
      end
      mhpq_pkg::S_POP_LAST: begin
        mov_key <= rd_key;
        mov_id  <= rd_id;
        pos     <= '0;
      end
      mhpq_pkg::S_DN_R: begin
        c_key  <= rd_key;
        c_id   <= rd_id;
        c_pick <= rd_key < mov_key;
        has_r  <= rc_in;
      end
      mhpq_pkg::S_DN_DEC: begin
        if (pick_r) begin
          pos <= rc_x[AW-1:0];
        end else if (c_pick) begin
          pos <= lc_x[AW-1:0];
        end
      end
      mhpq_pkg::S_SRCH: begin
        if (srch_hit) begin
          pos <= idx;
        end else begin
          idx <= idx + AW'(1);
        end
      end
      mhpq_pkg::S_CHG_PAR: begin
        if (mov_key < rd_key) begin
          pos <= par;
        end
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

  // result registers, shown for one cycle under done
  always_ff @(posedge clk) begin
    if (fin) begin
      status    <= fin_status;
      popped_id <= fin_pop ? pop_id : '0;
      entries   <= EW'(fill);
    end
  end

endmodule
